// File: hdl/dll_pkg.sv
// Shared types and constants for the doubly linked list engine.
package dll_pkg;

    localparam int CAPACITY = 256;
    localparam int DATA_W   = 32;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int HDL_W    = SLOT_W + 1;
    localparam logic [HDL_W-1:0] NONE_SLOT = HDL_W'(CAPACITY);

    typedef enum logic [3:0] {
        A_PUSH_TAIL   = 4'd0,
        A_PUSH_HEAD   = 4'd1,
        A_POP_TAIL    = 4'd2,
        A_POP_HEAD    = 4'd3,
        A_INSERT      = 4'd4,
        A_ERASE       = 4'd5,
        A_CLEAR       = 4'd6,
        A_READ_INDEX  = 4'd7,
        A_WRITE_INDEX = 4'd8,
        A_READ_HANDLE = 4'd9,
        A_STEP_NEXT   = 4'd10,
        A_STEP_PREV   = 4'd11,
        A_RSVD12      = 4'd12,
        A_RSVD13      = 4'd13,
        A_RSVD14      = 4'd14,
        A_RSVD15      = 4'd15
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_BAD   = 2'd3
    } t_status;

    typedef struct packed {
        logic              val_we;
        logic [SLOT_W-1:0] val_waddr;
        logic [DATA_W-1:0] val_wdata;
        logic [SLOT_W-1:0] val_raddr;
        logic              fwd_we;
        logic [SLOT_W-1:0] fwd_waddr;
        logic [HDL_W-1:0]  fwd_wdata;
        logic [SLOT_W-1:0] fwd_raddr;
        logic              bwd_we;
        logic [SLOT_W-1:0] bwd_waddr;
        logic [HDL_W-1:0]  bwd_wdata;
        logic [SLOT_W-1:0] bwd_raddr;
    } t_mem_req;

    typedef struct packed {
        logic [DATA_W-1:0] val_rdata;
        logic [HDL_W-1:0]  fwd_rdata;
        logic [HDL_W-1:0]  bwd_rdata;
    } t_mem_rsp;

endpackage

// File: hdl/doubly_linked_list_engine_unit.sv
// Top level: list sequencer around the slot memories, stream in and out.
//
//  channel   | dir | fields (tdata, low bit up)
//  s_axis    | in  | action[3:0] value[35:4] index[43:36] handle[52:44]
//  m_axis    | out | status[1:0] value_out[33:2] handle_out[42:34] count[51:43]
//            |     | front_value[83:52] back_value[115:84] first_handle[124:116]
//
//  Push, pop, insert, erase: check, exec, exec2; read/step at handle: check, exec; clear: check.
//  Rejected words and step back from end: check only.
//  Write by index: check, then walk/step per index, then access; read by index adds a value read.
//  Next word taken in the cycle after the result is loaded.
//  Reset is synchronous; no clearing pass, live bits reset at once.
//  A finished word waits in the output register while the next is taken.
module doubly_linked_list_engine_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [55:0]  i_s_axis_tdata,   // action, value, index, handle
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [127:0] o_m_axis_tdata    // status, value_out, handle_out, count,
                                           // front_value, back_value, first_handle
);

    localparam int SW = dll_pkg::SLOT_W;
    localparam int HW = dll_pkg::HDL_W;
    localparam int DW = dll_pkg::DATA_W;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_CHECK  = 9'b000000010,
        S_EXEC   = 9'b000000100,
        S_EXEC2  = 9'b000001000,
        S_WALK   = 9'b000010000,
        S_WSTEP  = 9'b000100000,
        S_ACCESS = 9'b001000000,
        S_RDV    = 9'b010000000,
        S_DONE   = 9'b100000000
    } t_state;

    t_state                   r_state;
    dll_pkg::t_action         r_act;
    logic [DW-1:0]            r_val;
    logic [SW-1:0]            r_idx;
    logic [HW-1:0]            r_hdl;
    logic [HW-1:0]            r_first, r_last, r_count, r_free, r_fresh;
    logic [dll_pkg::CAPACITY-1:0] r_live;
    logic [DW-1:0]            r_front, r_back;
    dll_pkg::t_status         r_status;
    logic [DW-1:0]            r_vout;
    logic [HW-1:0]            r_hout;
    logic [HW-1:0]            r_at, r_slot, r_p, r_n;
    logic [SW-1:0]            r_cur, r_rem;
    logic                     r_out_valid;
    logic [127:0]             r_out_data;

    dll_pkg::t_mem_req        c_req;
    dll_pkg::t_mem_rsp        c_rsp;

    logic                     c_link, c_unlink, c_full, c_h_live, c_free_ok;
    logic [HW-1:0]            c_at, c_tgt, c_s, c_p, c_lp, c_ln;

    dll_slot_mem u_mem (
        .i_clk (i_clk),
        .i_req (c_req),
        .o_rsp (c_rsp)
    );

    assign c_link   = (r_act == dll_pkg::A_PUSH_TAIL) || (r_act == dll_pkg::A_PUSH_HEAD) ||
                      (r_act == dll_pkg::A_INSERT);
    assign c_unlink = (r_act == dll_pkg::A_POP_TAIL) || (r_act == dll_pkg::A_POP_HEAD) ||
                      (r_act == dll_pkg::A_ERASE);
    assign c_full   = (r_count == dll_pkg::NONE_SLOT);
    assign c_h_live = !r_hdl[HW-1] && r_live[r_hdl[SW-1:0]];
    assign c_at     = (r_act == dll_pkg::A_PUSH_TAIL) ? dll_pkg::NONE_SLOT :
                      (r_act == dll_pkg::A_PUSH_HEAD) ? r_first : r_hdl;
    assign c_tgt    = (r_act == dll_pkg::A_POP_TAIL) ? r_last :
                      (r_act == dll_pkg::A_POP_HEAD) ? r_first : r_hdl;
    assign c_free_ok = (r_free != dll_pkg::NONE_SLOT);
    assign c_s      = c_free_ok ? r_free : r_fresh;
    assign c_p      = (r_at != dll_pkg::NONE_SLOT) ? c_rsp.bwd_rdata : r_last;
    assign c_lp     = c_rsp.bwd_rdata;
    assign c_ln     = c_rsp.fwd_rdata;

    always_comb begin
        c_req = '0;
        case (r_state)
            S_CHECK: begin
                c_req.fwd_raddr = c_link ? r_free[SW-1:0] : c_tgt[SW-1:0];
                c_req.bwd_raddr = c_link ? c_at[SW-1:0] : c_tgt[SW-1:0];
                c_req.val_raddr = c_tgt[SW-1:0];
            end
            S_EXEC: begin
                if (c_link) begin
                    c_req.val_we    = 1'b1;
                    c_req.val_waddr = c_s[SW-1:0];
                    c_req.val_wdata = r_val;
                    c_req.fwd_we    = 1'b1;
                    c_req.fwd_waddr = c_s[SW-1:0];
                    c_req.fwd_wdata = r_at;
                    c_req.bwd_we    = 1'b1;
                    c_req.bwd_waddr = c_s[SW-1:0];
                    c_req.bwd_wdata = c_p;
                end else if (c_unlink) begin
                    c_req.fwd_we    = (c_lp != dll_pkg::NONE_SLOT);
                    c_req.fwd_waddr = c_lp[SW-1:0];
                    c_req.fwd_wdata = c_ln;
                    c_req.bwd_we    = (c_ln != dll_pkg::NONE_SLOT);
                    c_req.bwd_waddr = c_ln[SW-1:0];
                    c_req.bwd_wdata = c_lp;
                    c_req.val_raddr = (c_lp == dll_pkg::NONE_SLOT) ? c_ln[SW-1:0]
                                                                   : c_lp[SW-1:0];
                end
            end
            S_EXEC2: begin
                if (c_link) begin
                    c_req.bwd_we    = (r_at != dll_pkg::NONE_SLOT);
                    c_req.bwd_waddr = r_at[SW-1:0];
                    c_req.bwd_wdata = r_slot;
                    c_req.fwd_we    = (r_p != dll_pkg::NONE_SLOT);
                    c_req.fwd_waddr = r_p[SW-1:0];
                    c_req.fwd_wdata = r_slot;
                end else begin
                    c_req.fwd_we    = 1'b1;
                    c_req.fwd_waddr = r_slot[SW-1:0];
                    c_req.fwd_wdata = r_free;
                end
            end
            S_WALK: begin
                c_req.fwd_raddr = r_cur;
            end
            S_ACCESS: begin
                c_req.val_raddr = r_cur;
                c_req.val_we    = (r_act == dll_pkg::A_WRITE_INDEX);
                c_req.val_waddr = r_cur;
                c_req.val_wdata = r_val;
            end
            default: begin
                c_req = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_first     <= dll_pkg::NONE_SLOT;
            r_last      <= dll_pkg::NONE_SLOT;
            r_count     <= '0;
            r_free      <= dll_pkg::NONE_SLOT;
            r_fresh     <= '0;
            r_live      <= '0;
            r_front     <= '0;
            r_back      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && (!r_out_valid || i_m_axis_tready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_act    <= dll_pkg::t_action'(i_s_axis_tdata[3:0]);
                        r_val    <= i_s_axis_tdata[35:4];
                        r_idx    <= i_s_axis_tdata[43:36];
                        r_hdl    <= i_s_axis_tdata[52:44];
                        r_status <= dll_pkg::ST_OK;
                        r_vout   <= '0;
                        r_hout   <= dll_pkg::NONE_SLOT;
                        r_state  <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_at    <= c_at;
                    r_slot  <= c_tgt;
                    r_cur   <= r_first[SW-1:0];
                    r_rem   <= r_idx;
                    case (r_act)
                        dll_pkg::A_PUSH_TAIL, dll_pkg::A_PUSH_HEAD: begin
                            if (c_full) begin
                                r_status <= dll_pkg::ST_FULL;
                                r_state  <= S_DONE;
                            end else begin
                                r_state  <= S_EXEC;
                            end
                        end
                        dll_pkg::A_INSERT: begin
                            if (r_hdl != dll_pkg::NONE_SLOT && !c_h_live) begin
                                r_status <= dll_pkg::ST_BAD;
                                r_state  <= S_DONE;
                            end else if (c_full) begin
                                r_status <= dll_pkg::ST_FULL;
                                r_state  <= S_DONE;
                            end else begin
                                r_state  <= S_EXEC;
                            end
                        end
                        dll_pkg::A_POP_TAIL, dll_pkg::A_POP_HEAD: begin
                            if (r_count == '0) begin
                                r_status <= dll_pkg::ST_EMPTY;
                                r_state  <= S_DONE;
                            end else begin
                                r_state  <= S_EXEC;
                            end
                        end
                        dll_pkg::A_ERASE, dll_pkg::A_READ_HANDLE,
                        dll_pkg::A_STEP_NEXT: begin
                            if (!c_h_live) begin
                                r_status <= dll_pkg::ST_BAD;
                                r_state  <= S_DONE;
                            end else begin
                                r_state  <= S_EXEC;
                            end
                        end
                        dll_pkg::A_STEP_PREV: begin
                            if (r_hdl == dll_pkg::NONE_SLOT) begin
                                if (r_last == dll_pkg::NONE_SLOT) r_status <= dll_pkg::ST_BAD;
                                else r_hout <= r_last;
                                r_state <= S_DONE;
                            end else if (!c_h_live) begin
                                r_status <= dll_pkg::ST_BAD;
                                r_state  <= S_DONE;
                            end else begin
                                r_state  <= S_EXEC;
                            end
                        end
                        dll_pkg::A_CLEAR: begin
                            r_first <= dll_pkg::NONE_SLOT;
                            r_last  <= dll_pkg::NONE_SLOT;
                            r_count <= '0;
                            r_free  <= dll_pkg::NONE_SLOT;
                            r_fresh <= '0;
                            r_live  <= '0;
                            r_front <= '0;
                            r_back  <= '0;
                            r_state <= S_DONE;
                        end
                        dll_pkg::A_READ_INDEX, dll_pkg::A_WRITE_INDEX: begin
                            if ({1'b0, r_idx} >= r_count) begin
                                r_status <= dll_pkg::ST_BAD;
                                r_state  <= S_DONE;
                            end else begin
                                r_state  <= S_WALK;
                            end
                        end
                        default: begin
                            r_status <= dll_pkg::ST_BAD;
                            r_state  <= S_DONE;
                        end
                    endcase
                end
                S_EXEC: begin
                    if (c_link) begin
                        if (c_free_ok) r_free <= c_rsp.fwd_rdata;
                        else r_fresh <= r_fresh + HW'(1);
                        r_live[c_s[SW-1:0]] <= 1'b1;
                        r_slot  <= c_s;
                        r_p     <= c_p;
                        r_count <= r_count + HW'(1);
                        if (r_at == dll_pkg::NONE_SLOT) begin
                            r_last <= c_s;
                            r_back <= r_val;
                        end
                        if (c_p == dll_pkg::NONE_SLOT) begin
                            r_first <= c_s;
                            r_front <= r_val;
                        end
                        if (r_act == dll_pkg::A_INSERT) r_hout <= c_s;
                        r_state <= S_EXEC2;
                    end else if (c_unlink) begin
                        if (c_lp == dll_pkg::NONE_SLOT) r_first <= c_ln;
                        if (c_ln == dll_pkg::NONE_SLOT) r_last <= c_lp;
                        r_count <= r_count - HW'(1);
                        r_live[r_slot[SW-1:0]] <= 1'b0;
                        r_p <= c_lp;
                        r_n <= c_ln;
                        if (r_act == dll_pkg::A_ERASE) r_hout <= c_ln;
                        r_state <= S_EXEC2;
                    end else begin
                        r_state <= S_DONE;
                        if (r_act == dll_pkg::A_READ_HANDLE) begin
                            r_vout <= c_rsp.val_rdata;
                        end else if (r_act == dll_pkg::A_STEP_NEXT) begin
                            r_hout <= c_rsp.fwd_rdata;
                        end else begin
                            if (c_rsp.bwd_rdata == dll_pkg::NONE_SLOT) begin
                                r_status <= dll_pkg::ST_BAD;
                            end else begin
                                r_hout <= c_rsp.bwd_rdata;
                            end
                        end
                    end
                end
                S_EXEC2: begin
                    if (c_unlink) begin
                        r_free <= r_slot;
                        if (r_p == dll_pkg::NONE_SLOT)
                            r_front <= (r_n == dll_pkg::NONE_SLOT) ? '0 : c_rsp.val_rdata;
                        if (r_n == dll_pkg::NONE_SLOT)
                            r_back <= (r_p == dll_pkg::NONE_SLOT) ? '0 : c_rsp.val_rdata;
                    end
                    r_state <= S_DONE;
                end
                S_WALK: begin
                    if (r_rem == '0) begin
                        r_state <= S_ACCESS;
                    end else begin
                        r_rem   <= r_rem - SW'(1);
                        r_state <= S_WSTEP;
                    end
                end
                S_WSTEP: begin
                    r_cur   <= c_rsp.fwd_rdata[SW-1:0];
                    r_state <= S_WALK;
                end
                S_ACCESS: begin
                    if (r_act == dll_pkg::A_WRITE_INDEX) begin
                        if ({1'b0, r_cur} == r_first) r_front <= r_val;
                        if ({1'b0, r_cur} == r_last) r_back <= r_val;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_RDV;
                    end
                end
                S_RDV: begin
                    r_vout  <= c_rsp.val_rdata;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_out_valid || i_m_axis_tready)) begin
            r_out_data <= {3'b000, r_first, r_back, r_front, r_count, r_hout, r_vout,
                           r_status};
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= dll_pkg::NONE_SLOT)
        else $error("element count above capacity");

    a_first_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ((r_count == '0) == (r_first == dll_pkg::NONE_SLOT)))
        else $error("first slot disagrees with count");

    a_last_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ((r_count == '0) == (r_last == dll_pkg::NONE_SLOT)))
        else $error("last slot disagrees with count");

    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_out_valid) |=> r_out_valid)
        else $error("finished word not loaded");
`endif

endmodule

// File: hdl/dll_slot_mem.sv
// Slot value, forward link and backward link memories with registered reads.
module dll_slot_mem (
    input  logic              i_clk,
    input  dll_pkg::t_mem_req i_req,
    output dll_pkg::t_mem_rsp o_rsp
);

    logic [dll_pkg::DATA_W-1:0] r_val_mem [dll_pkg::CAPACITY];
    logic [dll_pkg::HDL_W-1:0]  r_fwd_mem [dll_pkg::CAPACITY];
    logic [dll_pkg::HDL_W-1:0]  r_bwd_mem [dll_pkg::CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_req.val_we) begin
            r_val_mem[i_req.val_waddr] <= i_req.val_wdata;
        end
        if (i_req.fwd_we) begin
            r_fwd_mem[i_req.fwd_waddr] <= i_req.fwd_wdata;
        end
        if (i_req.bwd_we) begin
            r_bwd_mem[i_req.bwd_waddr] <= i_req.bwd_wdata;
        end
        o_rsp.val_rdata <= r_val_mem[i_req.val_raddr];
        o_rsp.fwd_rdata <= r_fwd_mem[i_req.fwd_raddr];
        o_rsp.bwd_rdata <= r_bwd_mem[i_req.bwd_raddr];
    end

endmodule

// File: test/dll_list_checker.sv
// Checker: watches both channels, predicts each result word and compares it.
`timescale 1ns / 100ps
module dll_list_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [55:0]  i_s_tdata,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [127:0] i_m_tdata,
    output int           o_fail_count,
    output int           o_pending
);
    localparam int SW = dll_pkg::SLOT_W;
    localparam int HW = dll_pkg::HDL_W;
    localparam int DW = dll_pkg::DATA_W;

    typedef struct packed {
        logic [HW-1:0] first_handle;
        logic [DW-1:0] back_value;
        logic [DW-1:0] front_value;
        logic [HW-1:0] count;
        logic [HW-1:0] handle_out;
        logic [DW-1:0] value_out;
        logic [1:0]    status;
    } t_result;

    logic [DW-1:0] slot_val [dll_pkg::CAPACITY];
    logic [HW-1:0] nxt [dll_pkg::CAPACITY];
    logic [HW-1:0] prv [dll_pkg::CAPACITY];
    logic          live [dll_pkg::CAPACITY];
    logic [HW-1:0] head, tail, free_head, fresh;
    int            elems;
    t_result       expected_words [$];

    function automatic logic is_live(logic [HW-1:0] h);
        return h < dll_pkg::NONE_SLOT && live[h[SW-1:0]];
    endfunction

    function automatic logic [HW-1:0] link_in(logic [HW-1:0] at, logic [DW-1:0] v);
        logic [HW-1:0] s, p;
        if (free_head < dll_pkg::NONE_SLOT) begin
            s = free_head;
            free_head = nxt[s[SW-1:0]];
        end else begin
            s = fresh;
            fresh++;
        end
        slot_val[s[SW-1:0]] = v;
        live[s[SW-1:0]] = 1'b1;
        p = (at < dll_pkg::NONE_SLOT) ? prv[at[SW-1:0]] : tail;
        prv[s[SW-1:0]] = p;
        nxt[s[SW-1:0]] = at;
        if (at < dll_pkg::NONE_SLOT) prv[at[SW-1:0]] = s; else tail = s;
        if (p < dll_pkg::NONE_SLOT) nxt[p[SW-1:0]] = s; else head = s;
        elems++;
        return s;
    endfunction

    function automatic logic [HW-1:0] unlink(logic [HW-1:0] s);
        logic [HW-1:0] p, n;
        p = prv[s[SW-1:0]];
        n = nxt[s[SW-1:0]];
        if (p < dll_pkg::NONE_SLOT) nxt[p[SW-1:0]] = n; else head = n;
        if (n < dll_pkg::NONE_SLOT) prv[n[SW-1:0]] = p; else tail = p;
        elems--;
        live[s[SW-1:0]] = 1'b0;
        nxt[s[SW-1:0]] = free_head;
        free_head = s;
        return n;
    endfunction

    function automatic t_result predict_list_op(logic [55:0] w);
        dll_pkg::t_action act;
        logic [DW-1:0]    v;
        logic [7:0]       idx;
        logic [HW-1:0]    h, s;
        t_result          r;
        act = dll_pkg::t_action'(w[3:0]);
        v = w[35:4];
        idx = w[43:36];
        h = w[52:44];
        r = '0;
        r.status = dll_pkg::ST_OK;
        r.handle_out = dll_pkg::NONE_SLOT;
        case (act)
            dll_pkg::A_PUSH_TAIL, dll_pkg::A_PUSH_HEAD: begin
                if (elems >= dll_pkg::CAPACITY) r.status = dll_pkg::ST_FULL;
                else void'(link_in(act == dll_pkg::A_PUSH_TAIL ? dll_pkg::NONE_SLOT : head,
                                   v));
            end
            dll_pkg::A_POP_TAIL, dll_pkg::A_POP_HEAD: begin
                s = (act == dll_pkg::A_POP_TAIL) ? tail : head;
                if (elems == 0) r.status = dll_pkg::ST_EMPTY;
                else void'(unlink(s));
            end
            dll_pkg::A_INSERT: begin
                if (h != dll_pkg::NONE_SLOT && !is_live(h)) r.status = dll_pkg::ST_BAD;
                else if (elems >= dll_pkg::CAPACITY) r.status = dll_pkg::ST_FULL;
                else r.handle_out = link_in(h, v);
            end
            dll_pkg::A_ERASE: begin
                if (!is_live(h)) r.status = dll_pkg::ST_BAD;
                else r.handle_out = unlink(h);
            end
            dll_pkg::A_CLEAR: begin
                foreach (live[i]) live[i] = 1'b0;
                head = dll_pkg::NONE_SLOT;
                tail = dll_pkg::NONE_SLOT;
                free_head = dll_pkg::NONE_SLOT;
                fresh = '0;
                elems = 0;
            end
            dll_pkg::A_READ_INDEX, dll_pkg::A_WRITE_INDEX: begin
                if (idx >= elems) r.status = dll_pkg::ST_BAD;
                else begin
                    s = head;
                    for (int i = 0; i < idx; i++) s = nxt[s[SW-1:0]];
                    if (act == dll_pkg::A_READ_INDEX) r.value_out = slot_val[s[SW-1:0]];
                    else slot_val[s[SW-1:0]] = v;
                end
            end
            dll_pkg::A_READ_HANDLE: begin
                if (!is_live(h)) r.status = dll_pkg::ST_BAD;
                else r.value_out = slot_val[h[SW-1:0]];
            end
            dll_pkg::A_STEP_NEXT: begin
                if (!is_live(h)) r.status = dll_pkg::ST_BAD;
                else r.handle_out = nxt[h[SW-1:0]];
            end
            dll_pkg::A_STEP_PREV: begin
                if (h == dll_pkg::NONE_SLOT) begin
                    if (tail < dll_pkg::NONE_SLOT) r.handle_out = tail;
                    else r.status = dll_pkg::ST_BAD;
                end else if (!is_live(h) || prv[h[SW-1:0]] >= dll_pkg::NONE_SLOT)
                    r.status = dll_pkg::ST_BAD;
                else r.handle_out = prv[h[SW-1:0]];
            end
            default: r.status = dll_pkg::ST_BAD;
        endcase
        r.count = HW'(elems);
        r.front_value = (head < dll_pkg::NONE_SLOT) ? slot_val[head[SW-1:0]] : '0;
        r.back_value = (tail < dll_pkg::NONE_SLOT) ? slot_val[tail[SW-1:0]] : '0;
        r.first_handle = head;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result got, want, pred;
        if (!i_rst_n) begin
            foreach (live[i]) live[i] = 1'b0;
            head = dll_pkg::NONE_SLOT;
            tail = dll_pkg::NONE_SLOT;
            free_head = dll_pkg::NONE_SLOT;
            fresh = '0;
            elems = 0;
            expected_words.delete();
            o_fail_count <= 0;
            o_pending <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                pred = predict_list_op(i_s_tdata);
                expected_words.insert(expected_words.size(), pred);
            end
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[124:0];
                if (expected_words.size() == 0) begin
                    if (o_fail_count < 10) $display("unexpected word %h", got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_words[0];
                    expected_words.delete(0);
                    if (got != want) begin
                        if (o_fail_count < 10)
                            $display("word mismatch: expected %h, got %h", want, got);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_pending <= expected_words.size();
        end
    end
endmodule

// File: test/tb_doubly_linked_list_engine_unit.sv
// Testbench top: clock, reset, list operation stimulus and verdict.
`timescale 1ns / 100ps
module tb_doubly_linked_list_engine_unit;

    localparam int WATCHDOG_LIMIT = 20000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [55:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    int           fail_count, pending;
    int           idle_cycles = 0;
    int           model_count = 0;
    int           burst_left = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    doubly_linked_list_engine_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready), .i_s_axis_tdata(s_tdata),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready), .o_m_axis_tdata(m_tdata)
    );

    dll_list_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver stall pattern: phases of always-ready, random, and heavy stall
    always @(negedge i_clk) begin
        int phase;
        phase = int'(($time / 30000) % 3);
        if (!i_rst_n) m_tready <= 1'b0;
        else if (phase == 0) m_tready <= 1'b1;
        else if (phase == 1) m_tready <= ($urandom_range(0, 3) != 0);
        else m_tready <= ($urandom_range(0, 3) == 0);
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_word(dll_pkg::t_action act, logic [31:0] v, logic [7:0] idx,
                             logic [8:0] h);
        if (burst_left == 0) begin
            repeat ($urandom_range(0, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_tdata <= {3'b0, h, idx, v, act};
        s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
        if (burst_left == 0) s_tvalid <= 1'b0;
        case (act)
            dll_pkg::A_PUSH_TAIL, dll_pkg::A_PUSH_HEAD, dll_pkg::A_INSERT:
                if (model_count < dll_pkg::CAPACITY) model_count++;
            dll_pkg::A_CLEAR: model_count = 0;
            default: ;
        endcase
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    function automatic logic [8:0] rand_handle();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 9'd256;
        if (r == 1) return 9'($urandom_range(0, 511));
        return 9'($urandom_range(0, (model_count > 0) ? model_count + 3 : 3));
    endfunction

    function automatic logic [7:0] rand_index();
        if ($urandom_range(0, 9) == 0) return 8'($urandom);
        return 8'($urandom_range(0, (model_count > 0) ? model_count : 0));
    endfunction

    initial begin
        dll_pkg::t_action act;
        int               r;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_word(dll_pkg::A_POP_TAIL, 32'h0, 8'd0, 9'd0);
        send_word(dll_pkg::A_POP_HEAD, 32'h0, 8'd0, 9'd0);
        send_word(dll_pkg::A_STEP_PREV, 32'h0, 8'd0, 9'd256);
        send_word(dll_pkg::A_READ_INDEX, 32'h0, 8'd0, 9'd0);
        send_word(dll_pkg::A_PUSH_TAIL, 32'h7FFF_FFFF, 8'd0, 9'd0);
        send_word(dll_pkg::A_PUSH_HEAD, 32'h8000_0000, 8'd0, 9'd0);
        send_word(dll_pkg::A_PUSH_TAIL, 32'hFFFF_FFFF, 8'd0, 9'd0);
        send_word(dll_pkg::A_INSERT, 32'h1234_5678, 8'd0, 9'd1);
        send_word(dll_pkg::A_INSERT, 32'h0, 8'd0, 9'd256);
        send_word(dll_pkg::A_INSERT, 32'h5, 8'd0, 9'd511);
        send_word(dll_pkg::A_STEP_PREV, 32'h0, 8'd0, 9'd1);
        send_word(dll_pkg::A_STEP_NEXT, 32'h0, 8'd0, 9'd4);
        send_word(dll_pkg::A_STEP_NEXT, 32'h0, 8'd0, 9'd2);
        send_word(dll_pkg::A_READ_HANDLE, 32'h0, 8'd0, 9'd3);
        send_word(dll_pkg::A_READ_INDEX, 32'h0, 8'd4, 9'd0);
        send_word(dll_pkg::A_WRITE_INDEX, 32'hA5A5_5A5A, 8'd2, 9'd0);
        send_word(dll_pkg::A_READ_INDEX, 32'h0, 8'd255, 9'd0);
        send_word(dll_pkg::A_ERASE, 32'h0, 8'd0, 9'd3);
        send_word(dll_pkg::A_ERASE, 32'h0, 8'd0, 9'd3);
        send_word(dll_pkg::A_PUSH_TAIL, 32'h0, 8'd0, 9'd0);
        send_word(dll_pkg::A_RSVD12, 32'h0, 8'd0, 9'd0);
        send_word(dll_pkg::A_RSVD15, 32'hFFFF_FFFF, 8'hFF, 9'h1FF);
        send_word(dll_pkg::A_CLEAR, 32'h0, 8'd0, 9'd0);
        drain();

        // fill to capacity, then hit the full case
        for (int i = 0; i < dll_pkg::CAPACITY + 2; i++)
            send_word(i % 2 ? dll_pkg::A_PUSH_HEAD : dll_pkg::A_PUSH_TAIL, $urandom,
                      8'd0, 9'd0);
        send_word(dll_pkg::A_INSERT, 32'h1, 8'd0, 9'd256);
        send_word(dll_pkg::A_INSERT, 32'h1, 8'd0, 9'd0);
        send_word(dll_pkg::A_READ_INDEX, 32'h0, 8'd255, 9'd0);
        send_word(dll_pkg::A_WRITE_INDEX, $urandom, 8'd255, 9'd0);
        send_word(dll_pkg::A_STEP_NEXT, 32'h0, 8'd0, 9'd255);
        send_word(dll_pkg::A_CLEAR, 32'h0, 8'd0, 9'd0);
        drain();

        for (int n = 0; n < 1110; n++) begin
            r = $urandom_range(0, 99);
            if (model_count > 40 && r < 30)
                act = (r < 15) ? dll_pkg::A_POP_TAIL : dll_pkg::A_ERASE;
            else if (r < 22) act = dll_pkg::A_PUSH_TAIL;
            else if (r < 32) act = dll_pkg::A_PUSH_HEAD;
            else if (r < 42) act = dll_pkg::A_INSERT;
            else if (r < 50) act = dll_pkg::A_ERASE;
            else if (r < 56) act = dll_pkg::A_POP_TAIL;
            else if (r < 61) act = dll_pkg::A_POP_HEAD;
            else if (r < 62) act = dll_pkg::A_CLEAR;
            else if (r < 70) act = dll_pkg::A_READ_INDEX;
            else if (r < 76) act = dll_pkg::A_WRITE_INDEX;
            else if (r < 84) act = dll_pkg::A_READ_HANDLE;
            else if (r < 91) act = dll_pkg::A_STEP_NEXT;
            else if (r < 98) act = dll_pkg::A_STEP_PREV;
            else act = dll_pkg::t_action'($urandom_range(12, 15));
            if (act == dll_pkg::A_POP_TAIL || act == dll_pkg::A_POP_HEAD ||
                act == dll_pkg::A_ERASE)
                if (model_count > 0) model_count--;
            send_word(act, $urandom, rand_index(), rand_handle());
            if (n == 555) drain();
        end
        drain();
        repeat (600) @(posedge i_clk);
        if (fail_count == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end
endmodule

// File: doubly_linked_list_engine_unit.f
hdl/dll_pkg.sv
hdl/dll_slot_mem.sv
hdl/doubly_linked_list_engine_unit.sv
test/dll_list_checker.sv
test/tb_doubly_linked_list_engine_unit.sv
